// File: rtl/ttm_pkg.sv
// package: types, constants and helpers of the trigger timestamp matcher
package ttm_pkg;

    localparam int RING_DEPTH = 16;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int STAMP_W    = 63;
    localparam int ENTRY_W    = 2 * STAMP_W;
    localparam int CODE_W     = 2;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TOL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WAIT  = 1'b1;

    localparam logic [STAMP_W-1:0] TOL_RESET  = STAMP_W'(64'd1000000);
    localparam logic [STAMP_W-1:0] WAIT_RESET = STAMP_W'(64'd1000000000);

    typedef logic [STAMP_W-1:0] t_stamp;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [CNT_W-1:0]   t_cnt;

    typedef enum logic [CODE_W-1:0] {
        CODE_STORED  = 2'd0,
        CODE_REFUSED = 2'd1,
        CODE_HELD    = 2'd2,
        CODE_FWD     = 2'd3
    } t_code;

    function automatic t_stamp abs_diff(input t_stamp a, input t_stamp b);
        t_stamp d_ab;
        t_stamp d_ba;
        d_ab = a - b;
        d_ba = b - a;
        return (a >= b) ? d_ab : d_ba;
    endfunction

    function automatic t_idx next_idx(input t_idx i);
        return (i == IDX_W'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

endpackage

// File: rtl/ttm_ram.sv
// generic single write port ram with registered read
module ttm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/trigger_timestamp_matcher_unit.sv
// top level: event ring in ram, trigger matching sequencer and result register
//
// Timing events (op 0) are appended to a ring of ttm_pkg::RING_DEPTH entries held in one
// synchronous ram; a full ring refuses the event. A trigger (op 1) walks the ring from the
// oldest event, dropping events whose UTC stamp is farther than match_tolerance_ns from the
// trigger stamp, and is forwarded with the precise stamp of the first event within tolerance,
// or with its own stamp if none is. On an empty ring the trigger is held and a wait timer
// starts at now_ns; once the wait exceeds max_wait_ns the trigger is forwarded with its own
// stamp and the late flag. One item is processed at a time: a store passes the start and
// output states, a trigger on an empty ring adds a wait compare step while a wait runs, and
// a trigger that walks the ring repeats the ram read, distance and compare steps for each
// event. A new request is taken once the previous result sits in the output register, even
// while that result is stalled. Configuration writes should be made while the block is idle.
module trigger_timestamp_matcher_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_op,
    input  logic [ttm_pkg::STAMP_W-1:0]      i_trigger_stamp,
    input  logic [ttm_pkg::STAMP_W-1:0]      i_event_stamp,
    input  logic [ttm_pkg::STAMP_W-1:0]      i_event_utc,
    input  logic [ttm_pkg::STAMP_W-1:0]      i_now_ns,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [ttm_pkg::CODE_W-1:0]       o_code,
    output logic [ttm_pkg::STAMP_W-1:0]      o_stamp_out,
    output logic                             o_late_flag,
    input  logic                             i_cfg_we,
    input  logic [ttm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ttm_pkg::STAMP_W-1:0]      i_cfg_data
);
    import ttm_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_START = 7'b0000010,
        S_RD    = 7'b0000100,
        S_DIFF  = 7'b0001000,
        S_CMP   = 7'b0010000,
        S_WCMP  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state;
    t_stamp r_tol;
    t_stamp r_max_wait;
    t_idx   r_head;
    t_idx   r_tail;
    t_cnt   r_count;
    logic   r_wait_active;
    t_stamp r_wait_start;

    logic   r_op;
    t_stamp r_trig;
    t_stamp r_ev_stamp;
    t_stamp r_ev_utc;
    t_stamp r_now;
    t_stamp r_diff;

    t_code  r_res_code;
    t_stamp r_res_stamp;
    logic   r_res_late;

    logic   r_out_valid;
    t_code  r_out_code;
    t_stamp r_out_stamp;
    logic   r_out_late;

    logic                 in_accept;
    logic                 out_free;
    logic                 ring_full;
    logic                 ram_we;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    t_stamp               ram_stamp;
    t_stamp               ram_utc;
    t_stamp               diff_a;
    t_stamp               diff_b;
    t_stamp               diff_val;

    assign in_accept = i_valid && !o_stall;
    assign out_free  = !r_out_valid || !i_stall;
    assign ring_full = (r_count == CNT_W'(RING_DEPTH));

    // event ring
    assign ram_we    = (r_state == S_START) && !r_op && !ring_full;
    assign ram_wdata = {r_ev_stamp, r_ev_utc};

    ttm_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_tail),
        .i_wdata(ram_wdata),
        .i_raddr(r_head),
        .o_rdata(ram_rdata)
    );

    assign ram_stamp = ram_rdata[ENTRY_W-1:STAMP_W];
    assign ram_utc   = ram_rdata[STAMP_W-1:0];

    // shared distance unit
    assign diff_a   = (r_state == S_DIFF) ? r_trig : r_now;
    assign diff_b   = (r_state == S_DIFF) ? ram_utc : r_wait_start;
    assign diff_val = abs_diff(diff_a, diff_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_tol         <= TOL_RESET;
            r_max_wait    <= WAIT_RESET;
            r_head        <= '0;
            r_tail        <= '0;
            r_count       <= '0;
            r_wait_active <= 1'b0;
            r_wait_start  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MATCH_TOL: r_tol      <= i_cfg_data;
                    CFG_MAX_WAIT:  r_max_wait <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    if (!r_op) begin
                        if (!ring_full) begin
                            r_tail  <= next_idx(r_tail);
                            r_count <= r_count + 1'b1;
                        end
                        r_state <= S_OUT;
                    end else if (r_count == '0) begin
                        if (!r_wait_active) begin
                            r_wait_active <= 1'b1;
                            r_wait_start  <= r_now;
                            r_state       <= S_OUT;
                        end else begin
                            r_state <= S_WCMP;
                        end
                    end else begin
                        r_state <= S_DIFF;
                    end
                end
                S_RD: begin
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_head  <= next_idx(r_head);
                    r_count <= r_count - 1'b1;
                    if (r_diff <= r_tol) begin
                        r_wait_active <= 1'b0;
                        r_state       <= S_OUT;
                    end else if (r_count == CNT_W'(1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_WCMP: begin
                    if (r_diff > r_max_wait) begin
                        r_wait_active <= 1'b0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // request capture, distance and result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op       <= i_op;
            r_trig     <= i_trigger_stamp;
            r_ev_stamp <= i_event_stamp;
            r_ev_utc   <= i_event_utc;
            r_now      <= i_now_ns;
        end

        if (r_state == S_START || r_state == S_DIFF) begin
            r_diff <= diff_val;
        end

        case (r_state)
            S_START: begin
                r_res_late <= 1'b0;
                if (!r_op) begin
                    r_res_code  <= ring_full ? CODE_REFUSED : CODE_STORED;
                    r_res_stamp <= '0;
                end else if (r_count == '0) begin
                    r_res_code  <= CODE_HELD;
                    r_res_stamp <= '0;
                end else begin
                    r_res_code  <= CODE_FWD;
                    r_res_stamp <= r_trig;
                end
            end
            S_CMP: begin
                if (r_diff <= r_tol) begin
                    r_res_stamp <= ram_stamp;
                end else begin
                    r_res_late <= 1'b1;
                end
            end
            S_WCMP: begin
                if (r_diff > r_max_wait) begin
                    r_res_code  <= CODE_FWD;
                    r_res_stamp <= r_trig;
                    r_res_late  <= 1'b1;
                end
            end
            default: ;
        endcase

        if (r_state == S_OUT && out_free) begin
            r_out_code  <= r_res_code;
            r_out_stamp <= r_res_stamp;
            r_out_late  <= r_res_late;
        end
    end

    assign o_stall     = (r_state != S_IDLE) || !i_rst_n;
    assign o_valid     = r_out_valid;
    assign o_code      = r_out_code;
    assign o_stamp_out = r_out_stamp;
    assign o_late_flag = r_out_late;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(RING_DEPTH))
        else $error("ring count beyond depth");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CNT_W'(RING_DEPTH)) |-> (r_head == r_tail))
        else $error("head and tail disagree with count");

    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIFF || r_state == S_CMP || r_state == S_RD) |-> (r_count != '0))
        else $error("ring walk on empty ring");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_START))
        else $error("accepted request not started");

    a_idle_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_code != CODE_FWD) |-> (o_stamp_out == '0 && !o_late_flag))
        else $error("non forward result carries stamp or flag");

endmodule

// File: dv/ttm_checker.sv
// checker for the trigger timestamp matcher: predicts each result from the accepted requests
`timescale 1ns / 100ps
module ttm_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic                          i_req_stall,
    input  logic                          i_op,
    input  ttm_pkg::t_stamp               i_trigger_stamp,
    input  ttm_pkg::t_stamp               i_event_stamp,
    input  ttm_pkg::t_stamp               i_event_utc,
    input  ttm_pkg::t_stamp               i_now_ns,
    input  logic                          i_rsp_valid,
    input  logic                          i_rsp_stall,
    input  logic [ttm_pkg::CODE_W-1:0]    i_code,
    input  ttm_pkg::t_stamp               i_stamp_out,
    input  logic                          i_late_flag,
    input  logic                          i_cfg_we,
    input  logic [ttm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  ttm_pkg::t_stamp               i_cfg_data,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_checked
);
    import ttm_pkg::*;

    typedef struct packed {
        t_code  code;
        t_stamp stamp;
        logic   late;
    } t_outcome;

    t_outcome outcome_q[$];
    t_outcome want;
    t_stamp   ring_stamp [RING_DEPTH];
    t_stamp   ring_utc   [RING_DEPTH];
    t_idx     head;
    t_idx     tail;
    t_cnt     fill;
    logic     waiting;
    t_stamp   wait_from;
    t_stamp   tol;
    t_stamp   max_wait;
    int       err_cnt;
    int       seen_cnt;

    initial begin
        err_cnt   = 0;
        seen_cnt  = 0;
    end

    function automatic t_stamp distance(input t_stamp a, input t_stamp b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic t_outcome match_request(input logic is_trigger, input t_stamp trig,
                                               input t_stamp ev_stamp, input t_stamp ev_utc,
                                               input t_stamp now);
        t_outcome r;
        t_idx     h;
        logic     found;
        r.code  = CODE_STORED;
        r.stamp = '0;
        r.late  = 1'b0;
        found   = 1'b0;
        if (!is_trigger) begin
            if (fill == t_cnt'(RING_DEPTH)) begin
                r.code = CODE_REFUSED;
            end else begin
                ring_stamp[tail] = ev_stamp;
                ring_utc[tail]   = ev_utc;
                tail = (tail == t_idx'(RING_DEPTH - 1)) ? '0 : tail + 1'b1;
                fill = fill + 1'b1;
            end
        end else if (fill == '0) begin
            if (!waiting) begin
                waiting   = 1'b1;
                wait_from = now;
            end
            if (distance(now, wait_from) > max_wait) begin
                waiting = 1'b0;
                r.code  = CODE_FWD;
                r.stamp = trig;
                r.late  = 1'b1;
            end else begin
                r.code = CODE_HELD;
            end
        end else begin
            r.code  = CODE_FWD;
            r.stamp = trig;
            while (fill != '0 && !found) begin
                h    = head;
                head = (head == t_idx'(RING_DEPTH - 1)) ? '0 : head + 1'b1;
                fill = fill - 1'b1;
                if (distance(trig, ring_utc[h]) > tol) begin
                    r.late = 1'b1;
                end else begin
                    waiting = 1'b0;
                    r.stamp = ring_stamp[h];
                    found   = 1'b1;
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            outcome_q.delete();
            head      = '0;
            tail      = '0;
            fill      = '0;
            waiting   = 1'b0;
            wait_from = '0;
            tol       = TOL_RESET;
            max_wait  = WAIT_RESET;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MATCH_TOL: tol = i_cfg_data;
                    CFG_MAX_WAIT:  max_wait = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_rsp_valid && !i_rsp_stall) begin
                if (outcome_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: result with nothing expected: code %0d stamp %0d late %0b",
                             $time, i_code, i_stamp_out, i_late_flag);
                end else begin
                    want = outcome_q.pop_front();
                    seen_cnt++;
                    if (i_code !== want.code) begin
                        err_cnt++;
                        $display("%0t: code expected %0d, actual %0d", $time, want.code, i_code);
                    end
                    if (i_stamp_out !== want.stamp) begin
                        err_cnt++;
                        $display("%0t: stamp_out expected %0d, actual %0d",
                                 $time, want.stamp, i_stamp_out);
                    end
                    if (i_late_flag !== want.late) begin
                        err_cnt++;
                        $display("%0t: late_flag expected %0b, actual %0b",
                                 $time, want.late, i_late_flag);
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                outcome_q.insert(outcome_q.size(),
                                 match_request(i_op, i_trigger_stamp, i_event_stamp,
                                               i_event_utc, i_now_ns));
            end
        end
        o_errors  <= err_cnt;
        o_pending <= outcome_q.size();
        o_checked <= seen_cnt;
    end

endmodule

// File: dv/testbench.sv
// testbench top: clock, reset, request and configuration stimulus, final verdict
`timescale 1ns / 100ps
module testbench;
    import ttm_pkg::*;

    localparam logic   OP_STORE    = 1'b0;
    localparam logic   OP_TRIGGER  = 1'b1;
    localparam int     TOTAL_REQS  = 550;
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     HOLD_CYCLES = 120;
    localparam t_stamp STAMP_MAX   = '1;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 dut_stall;
    logic                 req_op    = OP_STORE;
    t_stamp               req_trigger  = '0;
    t_stamp               req_ev_stamp = '0;
    t_stamp               req_ev_utc   = '0;
    t_stamp               req_now      = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    logic [CODE_W-1:0]    rsp_code;
    t_stamp               rsp_stamp;
    logic                 rsp_late;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_MATCH_TOL;
    t_stamp               cfg_data  = '0;

    int     err_total;
    int     pending;
    int     checked;
    int     cycle_cnt = 0;
    int     sent      = 0;
    int     stores    = 0;
    int     triggers  = 0;
    int     burst_left = 0;
    int     hold_seq  = 0;
    int     hold_seen = 0;
    int     hold_left = 0;
    int     rx_mode   = 0;
    int     rx_left   = 0;
    t_stamp tol_now   = TOL_RESET;
    t_stamp wait_now  = WAIT_RESET;
    t_stamp utc_base  = 63'd7000000;
    t_stamp now_base  = 63'd2000000000;

    always #1 clk = ~clk;

    trigger_timestamp_matcher_unit DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (req_valid),
        .o_stall         (dut_stall),
        .i_op            (req_op),
        .i_trigger_stamp (req_trigger),
        .i_event_stamp   (req_ev_stamp),
        .i_event_utc     (req_ev_utc),
        .i_now_ns        (req_now),
        .o_valid         (rsp_valid),
        .i_stall         (rsp_stall),
        .o_code          (rsp_code),
        .o_stamp_out     (rsp_stamp),
        .o_late_flag     (rsp_late),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    ttm_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_req_valid     (req_valid),
        .i_req_stall     (dut_stall),
        .i_op            (req_op),
        .i_trigger_stamp (req_trigger),
        .i_event_stamp   (req_ev_stamp),
        .i_event_utc     (req_ev_utc),
        .i_now_ns        (req_now),
        .i_rsp_valid     (rsp_valid),
        .i_rsp_stall     (rsp_stall),
        .i_code          (rsp_code),
        .i_stamp_out     (rsp_stamp),
        .i_late_flag     (rsp_late),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_errors        (err_total),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // receiver: long hold-off on request, otherwise a changing stall pattern
    always @(posedge clk) begin
        if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            case (rx_mode)
                0: rsp_stall <= 1'b0;
                1: rsp_stall <= ($urandom_range(0, 99) < 30);
                2: rsp_stall <= ($urandom_range(0, 99) < 75);
                default: rsp_stall <= (rx_left % 4 != 0);
            endcase
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    function automatic t_stamp rnd63();
        return t_stamp'({$urandom, $urandom});
    endfunction

    // value around center, often exactly lim away so limits are hit on the edge
    function automatic t_stamp near(input t_stamp center, input t_stamp lim);
        logic [63:0] spread;
        logic [63:0] off;
        spread = {1'b0, lim} + {2'b0, lim[STAMP_W-1:1]} + 64'd8;
        off    = {$urandom, $urandom} % (spread + 64'd1);
        if ($urandom_range(0, 4) == 0) begin
            off = {1'b0, lim} + 64'($urandom_range(0, 1));
        end
        return ($urandom_range(0, 1) != 0) ? center + off[STAMP_W-1:0]
                                           : center - off[STAMP_W-1:0];
    endfunction

    task automatic send_item(input logic op, input t_stamp trig, input t_stamp ev_stamp,
                             input t_stamp ev_utc, input t_stamp now);
        int gap;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_valid    <= 1'b1;
        req_op       <= op;
        req_trigger  <= trig;
        req_ev_stamp <= ev_stamp;
        req_ev_utc   <= ev_utc;
        req_now      <= now;
        @(posedge clk);
        while (dut_stall) @(posedge clk);
        burst_left--;
        sent++;
        if (op == OP_TRIGGER) triggers++;
        else stores++;
    endtask

    task automatic drain();
        req_valid  <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_limits(input t_stamp tol, input t_stamp max_wait);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MATCH_TOL;
        cfg_data  <= tol;
        @(posedge clk);
        cfg_index <= CFG_MAX_WAIT;
        cfg_data  <= max_wait;
        @(posedge clk);
        cfg_we   <= 1'b0;
        tol_now  = tol;
        wait_now = max_wait;
    endtask

    task automatic random_phase(input int quota, input bit with_hold);
        int stop_at;
        int hold_at;
        int n;
        int sel;
        stop_at = sent + quota;
        hold_at = sent + quota / 2;
        while (sent < stop_at) begin
            if (with_hold && sent >= hold_at) begin
                hold_seq <= hold_seq + 1;
                with_hold = 1'b0;
            end
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                n = ($urandom_range(0, 6) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
                repeat (n) begin
                    send_item(OP_STORE, rnd63(), rnd63(),
                              ($urandom_range(0, 9) == 0) ? rnd63() : near(utc_base, tol_now),
                              rnd63());
                    utc_base = utc_base
                             + t_stamp'({$urandom, $urandom} % ({1'b0, tol_now >> 2} + 64'd1));
                end
            end else if (sel < 70) begin
                repeat ($urandom_range(1, 3)) begin
                    send_item(OP_TRIGGER, near(utc_base, tol_now), rnd63(), rnd63(),
                              near(now_base, wait_now));
                end
            end else if (sel < 85) begin
                // clear the ring, then let the wait timer run across its limit
                send_item(OP_TRIGGER, utc_base ^ (t_stamp'(1) << (STAMP_W - 1)), rnd63(),
                          rnd63(), now_base);
                repeat ($urandom_range(1, 4)) begin
                    send_item(OP_TRIGGER, rnd63(), rnd63(), rnd63(), near(now_base, wait_now));
                end
                now_base = now_base + near(t_stamp'(0), wait_now);
            end else begin
                send_item($urandom_range(0, 1) ? OP_TRIGGER : OP_STORE,
                          rnd63(), rnd63(), rnd63(), rnd63());
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // wait timer on an empty ring, including now before the wait start
        send_item(OP_TRIGGER, rnd63(), '0, '0, 63'd100);
        send_item(OP_TRIGGER, rnd63(), '0, '0, 63'd100 + WAIT_RESET);
        send_item(OP_TRIGGER, rnd63(), '0, '0, 63'd101 + WAIT_RESET);
        send_item(OP_TRIGGER, rnd63(), '0, '0, 63'd5000);
        send_item(OP_TRIGGER, '0, '0, '0, '0);
        // ring emptied by discards keeps the wait running
        send_item(OP_STORE, STAMP_MAX, rnd63(), '0, STAMP_MAX);
        send_item(OP_TRIGGER, STAMP_MAX, '0, '0, '0);
        send_item(OP_TRIGGER, rnd63(), '0, '0, 63'd5001 + WAIT_RESET);
        // fill the ring, then one refused event
        for (int i = 0; i < RING_DEPTH; i++) begin
            send_item(OP_STORE, rnd63(),
                      (i == 0) ? STAMP_MAX : (i == 1) ? '0 : (i == 2) ? {21{3'b010}}
                               : (i == 3) ? {21{3'b101}} : rnd63(),
                      t_stamp'(64'd5000000 + 64'(i) * 64'd400000), rnd63());
        end
        send_item(OP_STORE, rnd63(), rnd63(), STAMP_MAX, rnd63());
        // match exactly at the tolerance edge, once after skipping events
        send_item(OP_TRIGGER, t_stamp'(64'd5000000 + 64'd1200000) + TOL_RESET, '0, '0, '0);
        send_item(OP_TRIGGER, t_stamp'(64'd5000000 + 64'd1600000) - TOL_RESET, '0, '0,
                  STAMP_MAX);

        drain();
        set_limits('0, '0);
        random_phase(130, 1'b1);
        drain();
        set_limits(STAMP_MAX, STAMP_MAX);
        random_phase(120, 1'b0);
        drain();
        set_limits(t_stamp'($urandom_range(100, 100000)), t_stamp'($urandom_range(1000, 1000000)));
        random_phase(140, 1'b1);
        drain();
        set_limits(TOL_RESET, WAIT_RESET);
        random_phase(TOTAL_REQS - sent, 1'b0);
        drain();

        $display("Run covered %0d requests (%0d event stores, %0d triggers) under five",
                 sent, stores, triggers);
        $display("register settings, with %0d results checked against prediction", checked);
        if (err_total == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
